@@ rtl/ragmt_pkg.sv @@
// Shared types and constants for the range-add / global-minimum tree.
// Used by range_add_global_min_tree_core and the testbench; no dependencies.
`default_nettype none

package ragmt_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned AMT_W  = 41;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned FIRST_W = 10;
  localparam int unsigned END_W  = 11;

  localparam logic [DATA_W-1:0] MIN_RESET = 64'h1000_0000_0000_0000;

  localparam logic [CMD_W-1:0] CMD_RANGE_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POINT_SET = 2'd1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PT_LEAF,
    ST_PT_FIRST,
    ST_PT_WALK,
    ST_PT_DIFF,
    ST_RANGE_START,
    ST_ROOT_RD,
    ST_ROOT_MIN,
    ST_ROOT_PEND,
    ST_DN_SEL,
    ST_DN_RDP,
    ST_DN_RDC,
    ST_DN_DELTA,
    ST_DN_WMIN,
    ST_DN_WPEND,
    ST_DN_CLEAR,
    ST_UP_SEL,
    ST_UP_RDL,
    ST_UP_RDR,
    ST_UP_WR,
    ST_FIN_RD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/range_add_global_min_tree_core.sv @@
// Lazy segment tree with range add, point set, point read and global minimum.
// Depends on ragmt_pkg and ragmt_ram (node minimum and pending-add memories).
//
// Usage: one request enters on the in_ channel, one result leaves on out_.
// A request is taken only while the sequencer is idle; one shared 64-bit
// adder and one compare work through the tree node by node.
// After reset a clearing pass writes every node while in_tready stays low.
// A point read walks from the leaf up to the root, summing pending adds. A
// range add walks the two boundary paths down, visiting each partially
// covered node, and back up; a point set reads the leaf, then adds the
// difference as a one-leaf range add. A range covering all leaves updates
// only the root; an empty range goes straight to the final root read.
// The result sits in an output register; a new request is taken while it
// waits, and the sequencer holds its next result until out_tready frees it.
`default_nettype none

module range_add_global_min_tree_core #(
  parameter int unsigned LEAVES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd[1:0], first_index[11:2], end_index[22:12], amount[63:23]
  input  wire logic [63:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // global_minimum[63:0], point_value[127:64]
  output logic      [127:0] out_tdata
);

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned W     = 1 << LW;
  localparam int unsigned NODES = 2 * W - 1;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned DW    = $clog2(LW + 1);
  localparam int unsigned PW    = (LW + 1 > 11) ? LW + 1 : 11;
  localparam int unsigned DTW   = ragmt_pkg::DATA_W;

  ragmt_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]  clr_r, clr_nxt;
  logic [1:0]     cmd_r, cmd_nxt;
  logic [PW-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [DTW-1:0] x_r, x_nxt, acc_r, acc_nxt, t_r, t_nxt, delta_r, delta_nxt;
  logic [DW-1:0]  lvl_r, lvl_nxt;
  logic           side_r, side_nxt, ch_r, ch_nxt;
  logic [NW-1:0]  k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [DTW-1:0] out_gmin_r, out_gmin_nxt, out_pv_r, out_pv_nxt;

  // Request fields
  logic [1:0]     in_cmd;
  logic [9:0]     in_first;
  logic [10:0]    in_end;
  logic [40:0]    in_amount;
  logic [PW-1:0]  in_a, in_b, in_b_clip;
  logic           accept;

  assign in_cmd    = in_tdata[1:0];
  assign in_first  = in_tdata[11:2];
  assign in_end    = in_tdata[22:12];
  assign in_amount = in_tdata[63:23];
  assign in_a      = PW'(in_first);
  assign in_b      = PW'(in_end);
  assign in_b_clip = (in_b > PW'(W)) ? PW'(W) : in_b;
  assign in_tready = (state_r == ragmt_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Memories
  logic           min_we, min_re, pend_we, pend_re;
  logic [NW-1:0]  min_wa, min_ra, pend_wa, pend_ra;
  logic [DTW-1:0] min_wd, pend_wd, min_rd, pend_rd;

  ragmt_ram #(.WIDTH(DTW), .DEPTH(NODES)) u_min_ram (
    .clk    (clk),
    .wr_en  (min_we),
    .wr_addr(min_wa),
    .wr_data(min_wd),
    .rd_en  (min_re),
    .rd_addr(min_ra),
    .rd_data(min_rd)
  );

  ragmt_ram #(.WIDTH(DTW), .DEPTH(NODES)) u_pend_ram (
    .clk    (clk),
    .wr_en  (pend_we),
    .wr_addr(pend_wa),
    .wr_data(pend_wd),
    .rd_en  (pend_re),
    .rd_addr(pend_ra),
    .rd_data(pend_rd)
  );

  // Current boundary node at level lvl_r on side side_r
  logic [PW-1:0] sh, src, p_cur, p_oth, lo, hi, half, mid, base;
  logic          partial, node_ok, cov0, cov1, cov_c, root_cov;
  logic [NW-1:0] k_cur, cl, cr, c_cur, parent;
  logic          dn_last, up_last;

  assign sh      = PW'(LW) - PW'(lvl_r);
  assign src     = side_r ? (b_r - PW'(1)) : a_r;
  assign p_cur   = src >> sh;
  assign p_oth   = a_r >> sh;
  assign lo      = p_cur << sh;
  assign hi      = (p_cur + PW'(1)) << sh;
  assign half    = PW'(1) << (sh - PW'(1));
  assign mid     = lo + half;
  assign partial = !((a_r <= lo) && (hi <= b_r));
  assign node_ok = partial && !(side_r && (p_cur == p_oth));
  assign base    = (PW'(1) << lvl_r) - PW'(1);
  assign k_cur   = NW'(base + p_cur);
  assign cl      = {k_cur[NW-2:0], 1'b1};
  assign cr      = cl + NW'(1);
  assign c_cur   = ch_r ? cr : cl;
  assign cov0    = (a_r <= lo) && (mid <= b_r);
  assign cov1    = (a_r <= mid) && (hi <= b_r);
  assign cov_c   = ch_r ? cov1 : cov0;
  assign root_cov = (a_r == '0) && (b_r == PW'(W));
  assign parent  = (k_r - NW'(1)) >> 1;
  assign dn_last = side_r && (lvl_r == DW'(LW - 1));
  assign up_last = side_r && (lvl_r == '0);

  // Shared adder
  logic [DTW-1:0] add_a, add_b, add_sum;
  logic           add_cin;

  assign add_sum = add_a + add_b + DTW'(add_cin);

  always_comb begin
    add_a   = acc_r;
    add_b   = pend_rd;
    add_cin = 1'b0;
    case (state_r)
      ragmt_pkg::ST_DN_DELTA: begin
        add_a = t_r;
        add_b = cov_c ? x_r : '0;
      end
      ragmt_pkg::ST_DN_WMIN: begin
        add_a = min_rd;
        add_b = delta_r;
      end
      ragmt_pkg::ST_DN_WPEND: begin
        add_a = pend_rd;
        add_b = delta_r;
      end
      ragmt_pkg::ST_ROOT_MIN: begin
        add_a = min_rd;
        add_b = x_r;
      end
      ragmt_pkg::ST_ROOT_PEND: begin
        add_a = pend_rd;
        add_b = x_r;
      end
      ragmt_pkg::ST_PT_DIFF: begin
        add_a   = x_r;
        add_b   = ~acc_r;
        add_cin = 1'b1;
      end
      default: begin
        add_a = acc_r;
        add_b = pend_rd;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ragmt_pkg::ST_CLEAR: begin
        if (clr_r == NW'(NODES - 1)) state_nxt = ragmt_pkg::ST_IDLE;
      end
      ragmt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd != ragmt_pkg::CMD_RANGE_ADD) begin
            state_nxt = ragmt_pkg::ST_PT_LEAF;
          end else if ((in_a < in_b) && (in_a < PW'(W))) begin
            state_nxt = ragmt_pkg::ST_RANGE_START;
          end else begin
            state_nxt = ragmt_pkg::ST_FIN_RD;
          end
        end
      end
      ragmt_pkg::ST_PT_LEAF:  state_nxt = ragmt_pkg::ST_PT_FIRST;
      ragmt_pkg::ST_PT_FIRST: state_nxt = ragmt_pkg::ST_PT_WALK;
      ragmt_pkg::ST_PT_WALK: begin
        if (k_r == '0) state_nxt = ragmt_pkg::ST_PT_DIFF;
      end
      ragmt_pkg::ST_PT_DIFF: begin
        state_nxt = (cmd_r == ragmt_pkg::CMD_POINT_SET) ? ragmt_pkg::ST_RANGE_START
                                                         : ragmt_pkg::ST_FIN_RD;
      end
      ragmt_pkg::ST_RANGE_START: begin
        state_nxt = root_cov ? ragmt_pkg::ST_ROOT_RD : ragmt_pkg::ST_DN_SEL;
      end
      ragmt_pkg::ST_ROOT_RD:   state_nxt = ragmt_pkg::ST_ROOT_MIN;
      ragmt_pkg::ST_ROOT_MIN:  state_nxt = ragmt_pkg::ST_ROOT_PEND;
      ragmt_pkg::ST_ROOT_PEND: state_nxt = ragmt_pkg::ST_FIN_RD;
      ragmt_pkg::ST_DN_SEL: begin
        if (node_ok) state_nxt = ragmt_pkg::ST_DN_RDP;
        else if (dn_last) state_nxt = ragmt_pkg::ST_UP_SEL;
      end
      ragmt_pkg::ST_DN_RDP:   state_nxt = ragmt_pkg::ST_DN_RDC;
      ragmt_pkg::ST_DN_RDC:   state_nxt = ragmt_pkg::ST_DN_DELTA;
      ragmt_pkg::ST_DN_DELTA: state_nxt = ragmt_pkg::ST_DN_WMIN;
      ragmt_pkg::ST_DN_WMIN:  state_nxt = ragmt_pkg::ST_DN_WPEND;
      ragmt_pkg::ST_DN_WPEND: begin
        state_nxt = ch_r ? ragmt_pkg::ST_DN_CLEAR : ragmt_pkg::ST_DN_RDC;
      end
      ragmt_pkg::ST_DN_CLEAR: begin
        state_nxt = dn_last ? ragmt_pkg::ST_UP_SEL : ragmt_pkg::ST_DN_SEL;
      end
      ragmt_pkg::ST_UP_SEL: begin
        if (node_ok) state_nxt = ragmt_pkg::ST_UP_RDL;
        else if (up_last) state_nxt = ragmt_pkg::ST_FIN_RD;
      end
      ragmt_pkg::ST_UP_RDL: state_nxt = ragmt_pkg::ST_UP_RDR;
      ragmt_pkg::ST_UP_RDR: state_nxt = ragmt_pkg::ST_UP_WR;
      ragmt_pkg::ST_UP_WR: begin
        state_nxt = up_last ? ragmt_pkg::ST_FIN_RD : ragmt_pkg::ST_UP_SEL;
      end
      ragmt_pkg::ST_FIN_RD: state_nxt = ragmt_pkg::ST_OUT;
      ragmt_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = ragmt_pkg::ST_IDLE;
      end
      default: state_nxt = ragmt_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers and memory control
  always_comb begin
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    delta_nxt     = delta_r;
    lvl_nxt       = lvl_r;
    side_nxt      = side_r;
    ch_nxt        = ch_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_gmin_nxt  = out_gmin_r;
    out_pv_nxt    = out_pv_r;
    min_we  = 1'b0;
    min_wa  = c_cur;
    min_wd  = add_sum;
    min_re  = 1'b0;
    min_ra  = c_cur;
    pend_we = 1'b0;
    pend_wa = c_cur;
    pend_wd = add_sum;
    pend_re = 1'b0;
    pend_ra = c_cur;
    case (state_r)
      ragmt_pkg::ST_CLEAR: begin
        min_we  = 1'b1;
        min_wa  = clr_r;
        min_wd  = ragmt_pkg::MIN_RESET;
        pend_we = 1'b1;
        pend_wa = clr_r;
        pend_wd = '0;
        clr_nxt = clr_r + NW'(1);
      end
      ragmt_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          x_nxt   = {{(DTW - 41){in_amount[40]}}, in_amount};
          acc_nxt = '0;
          if (in_cmd == ragmt_pkg::CMD_RANGE_ADD) begin
            a_nxt = in_a;
            b_nxt = in_b_clip;
          end else begin
            a_nxt = in_a & PW'(W - 1);
          end
        end
      end
      ragmt_pkg::ST_PT_LEAF: begin
        k_nxt  = NW'(PW'(W - 1) + a_r);
        min_re = 1'b1;
        min_ra = NW'(PW'(W - 1) + a_r);
      end
      ragmt_pkg::ST_PT_FIRST: begin
        acc_nxt = min_rd;
        k_nxt   = parent;
        pend_re = 1'b1;
        pend_ra = parent;
      end
      ragmt_pkg::ST_PT_WALK: begin
        acc_nxt = add_sum;
        if (k_r != '0) begin
          k_nxt   = parent;
          pend_re = 1'b1;
          pend_ra = parent;
        end
      end
      ragmt_pkg::ST_PT_DIFF: begin
        // turn the set into a one-leaf add of the difference
        x_nxt = add_sum;
        b_nxt = a_r + PW'(1);
      end
      ragmt_pkg::ST_RANGE_START: begin
        lvl_nxt  = '0;
        side_nxt = 1'b0;
      end
      ragmt_pkg::ST_ROOT_RD: begin
        min_re  = 1'b1;
        min_ra  = '0;
        pend_re = 1'b1;
        pend_ra = '0;
      end
      ragmt_pkg::ST_ROOT_MIN: begin
        min_we = 1'b1;
        min_wa = '0;
      end
      ragmt_pkg::ST_ROOT_PEND: begin
        pend_we = 1'b1;
        pend_wa = '0;
      end
      ragmt_pkg::ST_DN_SEL: begin
        ch_nxt = 1'b0;
        if (!node_ok) begin
          side_nxt = !side_r;
          if (side_r && !dn_last) lvl_nxt = lvl_r + DW'(1);
        end
      end
      ragmt_pkg::ST_DN_RDP: begin
        pend_re = 1'b1;
        pend_ra = k_cur;
      end
      ragmt_pkg::ST_DN_RDC: begin
        if (!ch_r) t_nxt = pend_rd;
        min_re  = 1'b1;
        pend_re = 1'b1;
      end
      ragmt_pkg::ST_DN_DELTA: begin
        delta_nxt = add_sum;
      end
      ragmt_pkg::ST_DN_WMIN: begin
        min_we = 1'b1;
      end
      ragmt_pkg::ST_DN_WPEND: begin
        pend_we = 1'b1;
        ch_nxt  = 1'b1;
      end
      ragmt_pkg::ST_DN_CLEAR: begin
        pend_we  = 1'b1;
        pend_wa  = k_cur;
        pend_wd  = '0;
        side_nxt = !side_r;
        if (side_r && !dn_last) lvl_nxt = lvl_r + DW'(1);
      end
      ragmt_pkg::ST_UP_SEL: begin
        if (!node_ok) begin
          side_nxt = !side_r;
          if (side_r && !up_last) lvl_nxt = lvl_r - DW'(1);
        end
      end
      ragmt_pkg::ST_UP_RDL: begin
        min_re = 1'b1;
        min_ra = cl;
      end
      ragmt_pkg::ST_UP_RDR: begin
        t_nxt  = min_rd;
        min_re = 1'b1;
        min_ra = cr;
      end
      ragmt_pkg::ST_UP_WR: begin
        min_we   = 1'b1;
        min_wa   = k_cur;
        min_wd   = ($signed(min_rd) < $signed(t_r)) ? min_rd : t_r;
        side_nxt = !side_r;
        if (side_r && !up_last) lvl_nxt = lvl_r - DW'(1);
      end
      ragmt_pkg::ST_FIN_RD: begin
        min_re = 1'b1;
        min_ra = '0;
      end
      ragmt_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_gmin_nxt  = min_rd;
          out_pv_nxt    = acc_r;
        end
      end
      default: begin
        clr_nxt = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ragmt_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      side_r      <= 1'b0;
      ch_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      side_r      <= side_nxt;
      ch_r        <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    delta_r    <= delta_nxt;
    k_r        <= k_nxt;
    out_gmin_r <= out_gmin_nxt;
    out_pv_r   <= out_pv_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pv_r, out_gmin_r};

endmodule

`default_nettype wire

@@ rtl/ragmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
`default_nettype none

module ragmt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2047
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_range_add_global_min_tree_core.sv @@
// Self-checking bench for range_add_global_min_tree_core: drives random range-add,
// point-set and point-read requests and compares each result with a local tree model.
// Depends on ragmt_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_range_add_global_min_tree_core;

  localparam int unsigned NLEAF = 1024;
  localparam int unsigned NODES = 2 * NLEAF - 1;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0] CMD_POINT_READ = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [40:0] amount;
    logic [10:0] end_index;
    logic [9:0]  first_index;
    logic [1:0]  cmd;
  } request_t;

  typedef struct packed {
    logic [63:0] point_value;
    logic [63:0] global_minimum;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;

  range_add_global_min_tree_core #(.LEAVES(NLEAF)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Tree model
  logic [63:0] tree_min [NODES];
  logic [63:0] tree_pend [NODES];

  request_t pending_reqs [$];
  reply_t   awaited_replies [$];

  int unsigned mismatch_count = 0;
  int unsigned reply_count = 0;
  int unsigned issued_count = 0;
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};
  longint unsigned cycle_count = 0;
  bit quiet_mode = 1'b0;      // no idling on either side
  bit hold_reader = 1'b0;     // long receiver hold-off
  bit sender_pause = 1'b0;

  function automatic logic [63:0] pick_min(logic [63:0] a, logic [63:0] b);
    return ($signed(b) < $signed(a)) ? b : a;
  endfunction

  function automatic void apply_mark(int unsigned k, logic [63:0] x);
    tree_min[k] = tree_min[k] + x;
    tree_pend[k] = tree_pend[k] + x;
  endfunction

  function automatic void tree_add(int unsigned a, int unsigned b, int unsigned k,
                                   int unsigned l, int unsigned r, logic [63:0] x);
    int unsigned m;
    if (r <= a || b <= l) return;
    if (a <= l && r <= b) begin
      apply_mark(k, x);
      return;
    end
    apply_mark(2 * k + 1, tree_pend[k]);
    apply_mark(2 * k + 2, tree_pend[k]);
    tree_pend[k] = '0;
    m = (l + r) / 2;
    tree_add(a, b, 2 * k + 1, l, m, x);
    tree_add(a, b, 2 * k + 2, m, r, x);
    tree_min[k] = pick_min(tree_min[2 * k + 1], tree_min[2 * k + 2]);
  endfunction

  function automatic logic [63:0] leaf_total(int unsigned idx);
    int unsigned k;
    logic [63:0] v;
    k = idx + NLEAF - 1;
    v = tree_min[k];
    while (k > 0) begin
      k = (k - 1) / 2;
      v = v + tree_pend[k];
    end
    return v;
  endfunction

  function automatic reply_t predict_reply(request_t rq);
    reply_t rp;
    logic [63:0] amt;
    int unsigned idx;
    amt = {{23{rq.amount[40]}}, rq.amount};
    rp.point_value = '0;
    if (rq.cmd == ragmt_pkg::CMD_RANGE_ADD) begin
      if (rq.first_index < rq.end_index)
        tree_add(32'(rq.first_index), 32'(rq.end_index), 0, 0, NLEAF, amt);
    end else begin
      idx = 32'(rq.first_index) % NLEAF;
      rp.point_value = leaf_total(idx);
      if (rq.cmd == ragmt_pkg::CMD_POINT_SET)
        tree_add(idx, idx + 1, 0, 0, NLEAF, amt - rp.point_value);
    end
    rp.global_minimum = tree_min[0];
    return rp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch on reply %0d: %s got %h want %h", reply_count, what, got, want);
  endtask

  function automatic request_t make_req(logic [1:0] c, int unsigned f, int unsigned e,
                                        logic [40:0] a);
    request_t rq;
    rq.cmd = c;
    rq.first_index = f[9:0];
    rq.end_index = e[10:0];
    rq.amount = a;
    return rq;
  endfunction

  function automatic void enqueue_req(request_t rq);
    pending_reqs = {pending_reqs, rq};
  endfunction

  function automatic logic [40:0] rand_amount();
    case ($urandom_range(0, 5))
      0: return {1'b0, {40{1'b1}}};
      1: return {1'b1, 40'b0};
      2: return 41'($signed($urandom_range(0, 200)) - 100);
      default: return 41'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic request_t rand_req();
    int unsigned f, e;
    logic [1:0] c;
    c = 2'($urandom_range(0, 9) < 5 ? 0 : $urandom_range(1, 3));
    f = $urandom_range(0, 1023);
    case ($urandom_range(0, 7))
      0: e = $urandom_range(0, 2047);
      1: e = f + 1;
      2: e = $urandom_range(0, f);
      3: e = 1024;
      default: e = $urandom_range(f, 1024);
    endcase
    return make_req(c, f, e, rand_amount());
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && !sender_pause &&
            (quiet_mode || $urandom_range(0, 99) >= 27)) begin
          request_t rq;
          rq = pending_reqs.pop_front();
          in_tdata <= rq;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Prediction on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      request_t rq;
      reply_t rp;
      rq = in_tdata;
      rp = predict_reply(rq);
      awaited_replies = {awaited_replies, rp};
      cmd_seen[rq.cmd]++;
      issued_count++;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        reply_t got, want;
        got = out_tdata;
        reply_count++;
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply", got.global_minimum, '0);
        end else begin
          want = awaited_replies.pop_front();
          if (got.global_minimum !== want.global_minimum)
            report_mismatch("global_minimum", got.global_minimum, want.global_minimum);
          if (got.point_value !== want.point_value)
            report_mismatch("point_value", got.point_value, want.point_value);
        end
      end
      out_tready <= !hold_reader && (quiet_mode || $urandom_range(0, 99) >= 27);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies awaited", cycle_count,
               awaited_replies.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check on the falling edge, when queues and handshakes have settled
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || awaited_replies.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int unsigned k;
    for (k = 0; k < NODES; k++) begin
      tree_min[k] = ragmt_pkg::MIN_RESET;
      tree_pend[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every command, empty/reversed/clipped ranges, spare command
    enqueue_req(make_req(CMD_POINT_READ, 0, 0, '0));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 0, 1024, {1'b1, 40'b0}));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 0, 2047, {1'b0, {40{1'b1}}}));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 5, 5, 41'd77));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 900, 100, 41'd77));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 1023, 1024, 41'h1FFFFFFFFFF));
    enqueue_req(make_req(CMD_POINT_READ, 1023, 0, '0));
    enqueue_req(make_req(ragmt_pkg::CMD_POINT_SET, 1023, 2047, {1'b1, 40'b0}));
    enqueue_req(make_req(ragmt_pkg::CMD_POINT_SET, 0, 0, {1'b0, {40{1'b1}}}));
    enqueue_req(make_req(CMD_SPARE, 512, 3, '0));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 1, 1023, 41'd3));
    enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 511, 513, 41'h1FFFFFFFF00));
    enqueue_req(make_req(CMD_POINT_READ, 512, 0, '0));
    // Repeated large adds over all leaves push the minimum up, far short of 2^63
    for (k = 0; k < 8; k++)
      enqueue_req(make_req(ragmt_pkg::CMD_RANGE_ADD, 0, 1024, {1'b0, {40{1'b1}}}));
    enqueue_req(make_req(CMD_POINT_READ, 300, 0, '0));
    wait_drained();

    // Long receiver stall while the sender keeps offering
    hold_reader = 1'b1;
    quiet_mode = 1'b1;
    for (k = 0; k < 20; k++) enqueue_req(rand_req());
    repeat (3000) @(posedge clk);
    hold_reader = 1'b0;
    wait_drained();
    quiet_mode = 1'b0;

    for (k = 0; k < 1700; k++) begin
      enqueue_req(rand_req());
      if (k == 600) quiet_mode = 1'b1;
      if (k == 900) quiet_mode = 1'b0;
      if (k == 1200) begin
        // sender pauses until every reply is in
        sender_pause = 1'b1;
        while (awaited_replies.size() != 0 || in_tvalid) @(negedge clk);
        sender_pause = 1'b0;
      end
      if (pending_reqs.size() > 8) @(posedge clk);
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (400) @(posedge clk);

    $display("%0d requests: %0d range adds, %0d point sets, %0d reads (+%0d spare code)",
             issued_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("%0d replies checked, %0d mismatches", reply_count, mismatch_count);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
